// File: sv/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
// Used by every module of the block except stt_fifo, and by its checker; depends on nothing.
package stt_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int LENGTH_BITS           = 16;
    localparam int MID_DEPTH             = 2;
    localparam int OUT_DEPTH             = 4;

    // Token kinds
    localparam logic [4:0] K_IDENT   = 5'd0;
    localparam logic [4:0] K_NUM     = 5'd1;
    localparam logic [4:0] K_STR     = 5'd2;
    localparam logic [4:0] K_CHAR    = 5'd3;
    localparam logic [4:0] K_PLUS    = 5'd4;
    localparam logic [4:0] K_MINUS   = 5'd5;
    localparam logic [4:0] K_STAR    = 5'd6;
    localparam logic [4:0] K_SLASH   = 5'd7;
    localparam logic [4:0] K_INC     = 5'd8;
    localparam logic [4:0] K_DEC     = 5'd9;
    localparam logic [4:0] K_POW     = 5'd10;
    localparam logic [4:0] K_DSLASH  = 5'd11;
    localparam logic [4:0] K_ASSIGN  = 5'd12;
    localparam logic [4:0] K_EQ      = 5'd13;
    localparam logic [4:0] K_NOT     = 5'd14;
    localparam logic [4:0] K_NE      = 5'd15;
    localparam logic [4:0] K_AND     = 5'd16;
    localparam logic [4:0] K_OR      = 5'd17;
    localparam logic [4:0] K_LPAREN  = 5'd18;
    localparam logic [4:0] K_RPAREN  = 5'd19;
    localparam logic [4:0] K_LBRACE  = 5'd20;
    localparam logic [4:0] K_RBRACE  = 5'd21;
    localparam logic [4:0] K_LBRACK  = 5'd22;
    localparam logic [4:0] K_RBRACK  = 5'd23;
    localparam logic [4:0] K_COLON   = 5'd24;
    localparam logic [4:0] K_SEMI    = 5'd25;
    localparam logic [4:0] K_QUEST   = 5'd26;
    localparam logic [4:0] K_COMMA   = 5'd27;
    localparam logic [4:0] K_INVALID = 5'd28;
    localparam logic [4:0] K_END     = 5'd29;

    // Characters
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef struct packed {
        logic       action;
        logic [7:0] text_byte;
    } in_t;

    typedef struct packed {
        logic [4:0]             token_kind;
        logic [LENGTH_BITS-1:0] token_length;
        logic [15:0]            token_row;
        logic [15:0]            token_column;
        logic                   last_of_run;
    } out_t;

    typedef struct packed {
        logic newline;
        logic space;
        logic letter;
        logic numeric;
        logic ident;
        logic oper;
        logic dquote;
        logic squote;
        logic hash;
    } cls_t;

    typedef struct packed {
        logic       action;
        logic [7:0] text_byte;
        cls_t       cls;
        logic [4:0] punct;
    } mid_t;

endpackage

// File: sv/stt_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Generic over the word type; depends on nothing.
module stt_fifo #(
    parameter type T     = logic [7:0],
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/stt_front.sv
// Front part of the tokenizer: sorts each incoming byte into character classes and punctuation kinds.
// Depends on stt_pkg for the word types and character codes.
module stt_front (
    input  stt_pkg::in_t  word,
    output stt_pkg::mid_t item
);

    logic [7:0] b;
    logic       is_digit;
    logic       is_letter;

    assign b         = word.text_byte;
    assign is_digit  = (b >= stt_pkg::CH_ZERO) && (b <= stt_pkg::CH_NINE);
    assign is_letter = ((b >= stt_pkg::CH_LOWER_A) && (b <= stt_pkg::CH_LOWER_Z)) ||
                       ((b >= stt_pkg::CH_UPPER_A) && (b <= stt_pkg::CH_UPPER_Z));

    always_comb
    begin
        item.action      = word.action;
        item.text_byte   = b;
        item.cls.newline = (b == stt_pkg::CH_NL);
        item.cls.space   = (b == stt_pkg::CH_TAB) || (b == stt_pkg::CH_CR) ||
                           (b == stt_pkg::CH_SPACE);
        item.cls.letter  = is_letter;
        item.cls.numeric = is_digit || (b == stt_pkg::CH_UNDER) || (b == stt_pkg::CH_DOT);
        item.cls.ident   = is_letter || is_digit || (b == stt_pkg::CH_UNDER);
        item.cls.oper    = (b == stt_pkg::CH_PLUS)  || (b == stt_pkg::CH_MINUS) ||
                           (b == stt_pkg::CH_STAR)  || (b == stt_pkg::CH_SLASH) ||
                           (b == stt_pkg::CH_PERCENT) || (b == stt_pkg::CH_EQUAL) ||
                           (b == stt_pkg::CH_LT)    || (b == stt_pkg::CH_GT) ||
                           (b == stt_pkg::CH_BANG)  || (b == stt_pkg::CH_CARET) ||
                           (b == stt_pkg::CH_AMP)   || (b == stt_pkg::CH_PIPE);
        item.cls.dquote  = (b == stt_pkg::CH_DQUOTE);
        item.cls.squote  = (b == stt_pkg::CH_SQUOTE);
        item.cls.hash    = (b == stt_pkg::CH_HASH);
        case (b)
            stt_pkg::CH_LPAREN: item.punct = stt_pkg::K_LPAREN;
            stt_pkg::CH_RPAREN: item.punct = stt_pkg::K_RPAREN;
            stt_pkg::CH_LBRACE: item.punct = stt_pkg::K_LBRACE;
            stt_pkg::CH_RBRACE: item.punct = stt_pkg::K_RBRACE;
            stt_pkg::CH_LBRACK: item.punct = stt_pkg::K_LBRACK;
            stt_pkg::CH_RBRACK: item.punct = stt_pkg::K_RBRACK;
            stt_pkg::CH_COLON:  item.punct = stt_pkg::K_COLON;
            stt_pkg::CH_SEMI:   item.punct = stt_pkg::K_SEMI;
            stt_pkg::CH_QUEST:  item.punct = stt_pkg::K_QUEST;
            stt_pkg::CH_COMMA:  item.punct = stt_pkg::K_COMMA;
            default:            item.punct = stt_pkg::K_INVALID;
        endcase
    end

endmodule

// File: sv/stt_back.sv
// Back part of the tokenizer: scan state machine, row/column counters, token build.
// Depends on stt_pkg; reads classified bytes from a queue and writes tokens to one.
module stt_back #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_empty,
    input  stt_pkg::mid_t item,
    output logic          item_pop,
    input  logic          res_full,
    output logic          res_push,
    output stt_pkg::out_t res
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_OPER,
        M_STRING,
        M_CHAR,
        M_COMMENT
    } mode_t;

    localparam int LB = stt_pkg::LENGTH_BITS;

    function automatic logic [4:0] oper_kind(input logic [7:0] f, input logic [7:0] s,
                                             input logic two);
        logic [4:0] k;
        begin
            case (f)
                stt_pkg::CH_PLUS:
                    k = two ? ((s == stt_pkg::CH_PLUS) ? stt_pkg::K_INC : stt_pkg::K_INVALID)
                            : stt_pkg::K_PLUS;
                stt_pkg::CH_MINUS:
                    k = two ? ((s == stt_pkg::CH_MINUS) ? stt_pkg::K_DEC : stt_pkg::K_INVALID)
                            : stt_pkg::K_MINUS;
                stt_pkg::CH_STAR:
                    k = two ? ((s == stt_pkg::CH_STAR) ? stt_pkg::K_POW : stt_pkg::K_INVALID)
                            : stt_pkg::K_STAR;
                stt_pkg::CH_SLASH:
                    k = two ? ((s == stt_pkg::CH_SLASH) ? stt_pkg::K_DSLASH
                                                        : stt_pkg::K_INVALID)
                            : stt_pkg::K_SLASH;
                stt_pkg::CH_EQUAL:
                    k = two ? ((s == stt_pkg::CH_EQUAL) ? stt_pkg::K_EQ : stt_pkg::K_INVALID)
                            : stt_pkg::K_ASSIGN;
                stt_pkg::CH_BANG:
                    k = two ? ((s == stt_pkg::CH_EQUAL) ? stt_pkg::K_NE : stt_pkg::K_INVALID)
                            : stt_pkg::K_NOT;
                stt_pkg::CH_CARET: k = two ? stt_pkg::K_INVALID : stt_pkg::K_POW;
                stt_pkg::CH_AMP:   k = two ? stt_pkg::K_INVALID : stt_pkg::K_AND;
                stt_pkg::CH_PIPE:  k = two ? stt_pkg::K_INVALID : stt_pkg::K_OR;
                default:           k = stt_pkg::K_INVALID;
            endcase
            return k;
        end
    endfunction

    mode_t                    mode_reg, mode_next;
    logic [7:0]               first_reg, first_next;
    logic [7:0]               second_reg, second_next;
    logic [LB-1:0]            len_reg, len_next;
    logic [POSITION_BITS-1:0] row_reg, row_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic                     pend_valid_reg, pend_valid_next;
    stt_pkg::out_t            pend_reg, pend_next;

    logic [31:0]              row_wide;
    logic [31:0]              col_wide;
    logic [POSITION_BITS-1:0] col_sat;
    logic [POSITION_BITS-1:0] row_sat;
    logic [LB-1:0]            len_sat;
    logic [4:0]               cur_kind;
    logic                     more;
    logic                     quote;
    logic                     do_idle;
    logic                     step;
    logic                     e1_v, e2_v;
    stt_pkg::out_t            e1, e2, cur_tok, pos_tok;

    assign row_wide = 32'(row_reg);
    assign col_wide = 32'(col_reg);
    assign col_sat  = (col_reg == '1) ? col_reg : col_reg + 1'b1;
    assign row_sat  = (row_reg == '1) ? row_reg : row_reg + 1'b1;
    assign len_sat  = (len_reg == '1) ? len_reg : len_reg + 1'b1;

    // Take a new byte only when no second token is held and the result queue has room.
    assign step     = !pend_valid_reg && !item_empty && !res_full;
    assign item_pop = step;
    assign res_push = (pend_valid_reg && !res_full) || (step && e1_v);
    assign res      = pend_valid_reg ? pend_reg : e1;

    always_comb
    begin
        case (mode_reg)
            M_IDENT:  cur_kind = stt_pkg::K_IDENT;
            M_NUMBER: cur_kind = stt_pkg::K_NUM;
            M_OPER:   cur_kind = oper_kind(first_reg, second_reg, len_reg > LB'(1));
            default:  cur_kind = stt_pkg::K_INVALID;
        endcase
        case (mode_reg)
            M_IDENT:  more = item.cls.ident;
            M_NUMBER: more = item.cls.numeric;
            default:  more = item.cls.oper;
        endcase
        quote = (mode_reg == M_STRING) ? item.cls.dquote : item.cls.squote;

        pos_tok.token_kind   = stt_pkg::K_INVALID;
        pos_tok.token_length = len_reg;
        pos_tok.token_row    = row_wide[15:0];
        pos_tok.token_column = col_wide[15:0];
        pos_tok.last_of_run  = 1'b0;
        cur_tok              = pos_tok;
        cur_tok.token_kind   = cur_kind;

        mode_next   = mode_reg;
        first_next  = first_reg;
        second_next = second_reg;
        len_next    = len_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        e1_v        = 1'b0;
        e2_v        = 1'b0;
        e1          = '0;
        e2          = '0;
        do_idle     = 1'b0;

        if (item.action)
        begin
            // Flush any open run, then the end marker; clear everything.
            if (mode_reg != M_IDLE && mode_reg != M_COMMENT)
            begin
                e1_v            = 1'b1;
                e1              = cur_tok;
                e2_v            = 1'b1;
                e2              = '0;
                e2.token_kind   = stt_pkg::K_END;
            end
            else
            begin
                e1_v          = 1'b1;
                e1            = '0;
                e1.token_kind = stt_pkg::K_END;
            end
            mode_next   = M_IDLE;
            first_next  = '0;
            second_next = '0;
            len_next    = '0;
            row_next    = '0;
            col_next    = '0;
        end
        else
        begin
            case (mode_reg)
                M_IDENT, M_NUMBER, M_OPER:
                begin
                    if (more)
                    begin
                        if (mode_reg == M_OPER && len_reg == LB'(1))
                        begin
                            second_next = item.text_byte;
                        end
                        len_next = len_sat;
                        col_next = col_sat;
                    end
                    else
                    begin
                        e1_v    = 1'b1;
                        e1      = cur_tok;
                        do_idle = 1'b1;
                    end
                end
                M_STRING, M_CHAR:
                begin
                    if (quote)
                    begin
                        e1_v = 1'b1;
                        e1   = pos_tok;
                        if (mode_reg == M_STRING)
                        begin
                            e1.token_kind = stt_pkg::K_STR;
                        end
                        else
                        begin
                            e1.token_kind = (len_reg > LB'(1)) ? stt_pkg::K_INVALID
                                                               : stt_pkg::K_CHAR;
                        end
                        col_next  = col_sat;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        len_next = len_sat;
                        col_next = col_sat;
                    end
                end
                M_COMMENT:
                begin
                    if (item.cls.newline)
                    begin
                        do_idle = 1'b1;
                    end
                    else
                    begin
                        col_next = col_sat;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // Rescan the byte from idle; counters are still the pre-byte values here.
            if (do_idle)
            begin
                mode_next = M_IDLE;
                if (item.cls.newline)
                begin
                    col_next = POSITION_BITS'(1);
                    row_next = row_sat;
                end
                else if (item.cls.space)
                begin
                    col_next = col_sat;
                end
                else if (item.cls.letter)
                begin
                    mode_next = M_IDENT;
                    len_next  = LB'(1);
                    col_next  = col_sat;
                end
                else if (item.cls.numeric)
                begin
                    mode_next = M_NUMBER;
                    len_next  = LB'(1);
                    col_next  = col_sat;
                end
                else if (item.cls.oper)
                begin
                    mode_next   = M_OPER;
                    first_next  = item.text_byte;
                    second_next = '0;
                    len_next    = LB'(1);
                    col_next    = col_sat;
                end
                else if (item.cls.dquote)
                begin
                    mode_next = M_STRING;
                    len_next  = '0;
                    col_next  = col_sat;
                end
                else if (item.cls.squote)
                begin
                    mode_next = M_CHAR;
                    len_next  = '0;
                    col_next  = col_sat;
                end
                else if (item.cls.hash)
                begin
                    mode_next = M_COMMENT;
                    len_next  = '0;
                    col_next  = col_sat;
                end
                else
                begin
                    if (e1_v)
                    begin
                        e2_v                = 1'b1;
                        e2                  = pos_tok;
                        e2.token_kind       = item.punct;
                        e2.token_length     = LB'(1);
                    end
                    else
                    begin
                        e1_v                = 1'b1;
                        e1                  = pos_tok;
                        e1.token_kind       = item.punct;
                        e1.token_length     = LB'(1);
                    end
                    col_next = col_sat;
                end
            end
        end

        e1.last_of_run = !e2_v;
        e2.last_of_run = 1'b1;

        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg && !res_full)
        begin
            pend_valid_next = 1'b0;
        end
        else if (step && e2_v)
        begin
            pend_valid_next = 1'b1;
            pend_next       = e2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            first_reg      <= '0;
            second_reg     <= '0;
            len_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            if (step)
            begin
                mode_reg   <= mode_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                len_reg    <= len_next;
                row_reg    <= row_next;
                col_reg    <= col_next;
            end
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

endmodule

// File: sv/source_text_tokenizer.sv
// Top level of the source text tokenizer.
// Depends on stt_pkg, stt_front, stt_fifo and stt_back.
//
// Usage:
//   Input side is a queue: drive source and raise push; a word is taken at a
//   clock edge with push high and full low. action 0 carries one text byte,
//   action 1 marks end of text and produces an end token.
//   Result side is a queue: while empty is low the oldest token sits on
//   token; raise pop to take it.
//   Throughput: one byte per cycle while the result queue has room. A byte that
//   closes one token and forms a second (or end of text after an open run)
//   holds the scanner while the second token waits in a holding register,
//   as the result queue has a single write port. A token is on the result
//   ports once written into the result queue, if that queue was empty.
//   Reset clears the scanner to idle with row and column at zero and empties
//   both queues. When pop stays low the result queue fills, the scanner
//   stops, the two-entry byte queue fills and full rises; nothing is dropped.
module source_text_tokenizer #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  stt_pkg::in_t  source,
    output logic          empty,
    input  logic          pop,
    output stt_pkg::out_t token
);

    stt_pkg::mid_t mid_wdata;
    stt_pkg::mid_t mid_rdata;
    logic          mid_empty;
    logic          mid_pop;
    logic          res_full;
    logic          res_push;
    stt_pkg::out_t res_word;

    stt_front u_front (
        .word (source),
        .item (mid_wdata)
    );

    stt_fifo #(
        .T     (stt_pkg::mid_t),
        .DEPTH (stt_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (mid_wdata),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    stt_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_empty (mid_empty),
        .item       (mid_rdata),
        .item_pop   (mid_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_word)
    );

    stt_fifo #(
        .T     (stt_pkg::out_t),
        .DEPTH (stt_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (token),
        .empty (empty)
    );

endmodule

// File: sv/stt_checker.sv
// Port-level checks for the source text tokenizer, bound to its top level.
// Depends on stt_pkg and source_text_tokenizer.
module stt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          push,
    input logic          full,
    input stt_pkg::in_t  source,
    input logic          empty,
    input logic          pop,
    input stt_pkg::out_t token
);

    // Both queues come out of reset drained.
    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

    // A waiting token must not change or vanish while it is not popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(token)))
        else $error("result word changed while stalled");

    // End token carries zero length and position and closes its run.
    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token.token_kind == stt_pkg::K_END) |->
        (token.token_length == '0 && token.token_row == '0 &&
         token.token_column == '0 && token.last_of_run))
        else $error("malformed end token");

    // The second token of a run follows right after the first is popped.
    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !token.last_of_run) |=> !empty)
        else $error("run ended without its last token");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .source (source),
    .empty  (empty),
    .pop    (pop),
    .token  (token)
);
